### rtl/core/sssd_pkg.sv
package sssd_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int STORE_DIGITS   = 4;
  localparam int POS_W          = 3;

  localparam logic [13:0] NUMBER_MAX = 14'd9999;
  localparam logic [7:0]  POINT_BIT  = 8'h80;

  typedef enum logic [1:0] {
    REQ_WRITE_DIGITS = 2'd0,
    REQ_WRITE_NUMBER = 2'd1,
    REQ_SET_POINT    = 2'd2,
    REQ_SCAN_TICK    = 2'd3
  } sssd_req_t;

  typedef struct packed {
    sssd_req_t                req;
    logic [3:0][3:0]          digit;
    logic [3:0]               thousands;
    logic [9:0]               below_thousand;
    logic signed [3:0]        point;
  } sssd_item_t;

  function automatic logic [3:0] clamp_digit(input logic signed [5:0] v);
    logic [3:0] r;
    if (v[5]) begin
      r = 4'd0;
    end else if (v[4]) begin
      r = 4'd15;
    end else begin
      r = v[3:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] glyph(input logic [3:0] idx);
    logic [7:0] g;
    unique case (idx)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      4'hF: g = 8'h71;
      default: g = 8'h3F;
    endcase
    return g;
  endfunction

endpackage

### rtl/core/sssd_front.sv
module sssd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic signed [5:0]        in_digit_value_0,
  input  logic signed [5:0]        in_digit_value_1,
  input  logic signed [5:0]        in_digit_value_2,
  input  logic signed [5:0]        in_digit_value_3,
  input  logic signed [14:0]       in_number_value,
  input  logic signed [3:0]        in_point_position,
  input  logic                     take,
  output logic                     item_valid,
  output sssd_pkg::sssd_item_t     item
);
  import sssd_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  sssd_item_t  item_r;
  sssd_item_t  item_nxt;
  logic [13:0] num_clamped;
  logic [27:0] thou_prod;
  logic [3:0]  thou;
  logic [13:0] thou_rem;
  logic        load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (in_number_value[14]) begin
      num_clamped = 14'd0;
    end else if (in_number_value[13:0] > NUMBER_MAX) begin
      num_clamped = NUMBER_MAX;
    end else begin
      num_clamped = in_number_value[13:0];
    end
    thou_prod = 28'(num_clamped) * 28'd8389;
    thou      = thou_prod[26:23];
    thou_rem  = num_clamped - 14'(thou) * 14'd1000;

    item_nxt.req            = sssd_req_t'(in_req_type);
    item_nxt.digit[0]       = clamp_digit(in_digit_value_0);
    item_nxt.digit[1]       = clamp_digit(in_digit_value_1);
    item_nxt.digit[2]       = clamp_digit(in_digit_value_2);
    item_nxt.digit[3]       = clamp_digit(in_digit_value_3);
    item_nxt.thousands      = thou;
    item_nxt.below_thousand = thou_rem[9:0];
    item_nxt.point          = in_point_position;

    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/core/seven_segment_scan_driver_unit.sv
// Four-digit multiplexed seven-segment scan driver.
// Input channel (in_valid / in_ready) carries one request per transaction:
// write digits, write number, set point or scan tick. Only a scan tick
// produces an output transaction (out_valid / out_ready) carrying the
// segment pattern (a..g in bits 0..6, point in bit 7) and the select code
// of the digit being driven; the scan then advances and wraps after
// NUM_DIGITS digits. Digits above the four stored ones show the zero
// glyph with no point.
// An accepted tick sits in the input register, moves into the result
// register once the result register is free or being taken, and is
// offered on the output from then on. Throughput: one transaction per
// cycle while the receiver does not stall.
// Writes issued after a tick never affect that tick's result.
// Reset (rst_n low, synchronous) clears all digits, points and the scan
// position, and empties both pipeline registers.
// When the receiver stalls, the result register holds; writes keep
// flowing, and a further tick waits in the input register, which then
// drops in_ready until the result register frees up.
module seven_segment_scan_driver_unit #(
  parameter int NUM_DIGITS = sssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic signed [5:0]   in_digit_value_0,
  input  logic signed [5:0]   in_digit_value_1,
  input  logic signed [5:0]   in_digit_value_2,
  input  logic signed [5:0]   in_digit_value_3,
  input  logic signed [14:0]  in_number_value,
  input  logic signed [3:0]   in_point_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_segment_bits,
  output logic [1:0]          out_select_code
);
  import sssd_pkg::*;

  localparam int SCAN_W    = $clog2(NUM_DIGITS);
  localparam int POINT_LIM = (NUM_DIGITS < STORE_DIGITS) ? NUM_DIGITS : STORE_DIGITS;

  logic            item_valid;
  sssd_item_t      item;
  logic            take;
  logic            tick;

  logic [3:0][3:0] glyph_r;
  logic [3:0][3:0] glyph_nxt;
  logic [3:0]      point_r;
  logic [3:0]      point_nxt;
  logic [SCAN_W-1:0] scan_r;
  logic [SCAN_W-1:0] scan_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [7:0]      seg_r;
  logic [7:0]      seg_nxt;
  logic [1:0]      sel_r;
  logic [1:0]      sel_nxt;

  logic [15:0]     hund_prod;
  logic [17:0]     t10_prod;
  logic [3:0]      hund;
  logic [6:0]      t10;
  logic [6:0]      tens_full;
  logic [9:0]      units_full;
  logic [POS_W-1:0] pos;
  logic [3:0]      pos_glyph;
  logic            pos_point;
  logic            point_ok;

  sssd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_digit_value_0  (in_digit_value_0),
    .in_digit_value_1  (in_digit_value_1),
    .in_digit_value_2  (in_digit_value_2),
    .in_digit_value_3  (in_digit_value_3),
    .in_number_value   (in_number_value),
    .in_point_position (in_point_position),
    .take              (take),
    .item_valid        (item_valid),
    .item              (item)
  );

  assign tick = (item.req == REQ_SCAN_TICK);
  assign take = item_valid && (!tick || !out_valid_r || out_ready);

  always_comb begin
    hund_prod  = 16'(item.below_thousand) * 16'd41;
    t10_prod   = 18'(item.below_thousand) * 18'd205;
    hund       = hund_prod[15:12];
    t10        = t10_prod[17:11];
    tens_full  = t10 - 7'(hund) * 7'd10;
    units_full = item.below_thousand - 10'(t10) * 10'd10;

    pos       = POS_W'(scan_r);
    pos_glyph = pos[2] ? 4'd0 : glyph_r[pos[1:0]];
    pos_point = pos[2] ? 1'b0 : point_r[pos[1:0]];
    point_ok  = !item.point[3] && ({1'b0, item.point[2:0]} < 4'(POINT_LIM));

    glyph_nxt     = glyph_r;
    point_nxt     = point_r;
    scan_nxt      = scan_r;
    seg_nxt       = seg_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (take) begin
      unique case (item.req)
        REQ_WRITE_DIGITS: begin
          glyph_nxt = item.digit;
        end
        REQ_WRITE_NUMBER: begin
          glyph_nxt[0] = item.thousands;
          glyph_nxt[1] = hund;
          glyph_nxt[2] = tens_full[3:0];
          glyph_nxt[3] = units_full[3:0];
          point_nxt    = 4'b0000;
        end
        REQ_SET_POINT: begin
          point_nxt = point_ok ? (4'b0001 << item.point[1:0]) : 4'b0000;
        end
        REQ_SCAN_TICK: begin
          seg_nxt       = glyph(pos_glyph) | (pos_point ? POINT_BIT : 8'h00);
          sel_nxt       = pos[1:0];
          out_valid_nxt = 1'b1;
          scan_nxt      = (scan_r == SCAN_W'(NUM_DIGITS - 1)) ? '0 : scan_r + 1'b1;
        end
        default: begin
          glyph_nxt = glyph_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r     <= '0;
      point_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      glyph_r     <= glyph_nxt;
      point_r     <= point_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    sel_r <= sel_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_segment_bits = seg_r;
  assign out_select_code  = sel_r;

endmodule

### test/tb_seven_segment_scan_driver_unit.sv
`timescale 1ns / 100ps

module tb_seven_segment_scan_driver_unit;
  import sssd_pkg::*;

  localparam int ITEM_COUNT = 550;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 120;

  localparam logic [7:0] GLYPH_ROM [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    sssd_req_t       kind;
    logic [3:0][5:0] digit;
    logic [14:0]     number;
    logic [3:0]      point;
  } display_req_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [1:0] select;
  } scan_result_t;

  class display_scoreboard;
    logic [3:0]   glyph_idx [STORE_DIGITS];
    bit           point_on [STORE_DIGITS];
    int           scan_pos;
    scan_result_t pending [$];
    int           errors;

    function new();
      for (int i = 0; i < STORE_DIGITS; i++) begin
        glyph_idx[i] = '0;
        point_on[i] = 1'b0;
      end
      scan_pos = 0;
      errors = 0;
    endfunction

    function void note_request(display_req_t r);
      int v;
      scan_result_t res;
      case (r.kind)
        REQ_WRITE_DIGITS: begin
          for (int i = 0; i < STORE_DIGITS; i++) begin
            v = $signed(r.digit[i]);
            if (v < 0) v = 0;
            if (v > 15) v = 15;
            glyph_idx[i] = v[3:0];
          end
        end
        REQ_WRITE_NUMBER: begin
          v = $signed(r.number);
          if (v < 0) v = 0;
          if (v > int'(NUMBER_MAX)) v = int'(NUMBER_MAX);
          glyph_idx[0] = 4'((v / 1000) % 10);
          glyph_idx[1] = 4'((v / 100) % 10);
          glyph_idx[2] = 4'((v / 10) % 10);
          glyph_idx[3] = 4'(v % 10);
          foreach (point_on[i]) point_on[i] = 1'b0;
        end
        REQ_SET_POINT: begin
          v = $signed(r.point);
          foreach (point_on[i]) point_on[i] = 1'b0;
          if (v >= 0 && v < NUM_DIGITS_DEF && v < STORE_DIGITS) point_on[v] = 1'b1;
        end
        default: begin
          if (scan_pos < STORE_DIGITS) begin
            res.segments = GLYPH_ROM[glyph_idx[scan_pos]];
            if (point_on[scan_pos]) res.segments = res.segments | POINT_BIT;
          end else begin
            res.segments = GLYPH_ROM[0];
          end
          res.select = 2'(scan_pos);
          pending.push_back(res);
          scan_pos = (scan_pos + 1 >= NUM_DIGITS_DEF) ? 0 : scan_pos + 1;
        end
      endcase
    endfunction

    function void check_result(logic [7:0] segments, logic [1:0] select);
      scan_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result segments=%h select=%0d", $time, segments, select);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (segments !== exp_res.segments) begin
        $display("%0t: segment_bits expected %h actual %h", $time, exp_res.segments, segments);
        errors++;
      end
      if (select !== exp_res.select) begin
        $display("%0t: select_code expected %0d actual %0d", $time, exp_res.select, select);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic signed [5:0]  in_digit_value_0;
  logic signed [5:0]  in_digit_value_1;
  logic signed [5:0]  in_digit_value_2;
  logic signed [5:0]  in_digit_value_3;
  logic signed [14:0] in_number_value;
  logic signed [3:0]  in_point_position;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_segment_bits;
  logic [1:0]         out_select_code;

  display_scoreboard sb = new();
  bit steady = 1'b0;
  bit holdoff_go = 1'b0;
  bit holdoff_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  seven_segment_scan_driver_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_digit_value_0  (in_digit_value_0),
    .in_digit_value_1  (in_digit_value_1),
    .in_digit_value_2  (in_digit_value_2),
    .in_digit_value_3  (in_digit_value_3),
    .in_number_value   (in_number_value),
    .in_point_position (in_point_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_segment_bits  (out_segment_bits),
    .out_select_code   (out_select_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [5:0] rand_digit();
    int v;
    if ($urandom_range(1) == 1) v = $urandom;
    else v = int'($urandom_range(19)) - 2;
    return v[5:0];
  endfunction

  function automatic logic [14:0] rand_number();
    int v;
    if ($urandom_range(1) == 1) v = $urandom;
    else v = $urandom_range(10005);
    return v[14:0];
  endfunction

  function automatic display_req_t rand_request(sssd_req_t kind);
    display_req_t r;
    r.kind = kind;
    for (int i = 0; i < 4; i++) r.digit[i] = rand_digit();
    r.number = rand_number();
    r.point = 4'($urandom);
    return r;
  endfunction

  task automatic drive_request(display_req_t r);
    if (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= r.kind;
    in_digit_value_0  <= r.digit[0];
    in_digit_value_1  <= r.digit[1];
    in_digit_value_2  <= r.digit[2];
    in_digit_value_3  <= r.digit[3];
    in_number_value   <= r.number;
    in_point_position <= r.point;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    drive_request(rand_request(REQ_SCAN_TICK));
  endtask

  task automatic send_digits(int d0, int d1, int d2, int d3);
    display_req_t r;
    r = rand_request(REQ_WRITE_DIGITS);
    r.digit[0] = 6'(d0);
    r.digit[1] = 6'(d1);
    r.digit[2] = 6'(d2);
    r.digit[3] = 6'(d3);
    drive_request(r);
  endtask

  task automatic send_number(int n);
    display_req_t r;
    r = rand_request(REQ_WRITE_NUMBER);
    r.number = 15'(n);
    drive_request(r);
  endtask

  task automatic send_point(int p);
    display_req_t r;
    r = rand_request(REQ_SET_POINT);
    r.point = 4'(p);
    drive_request(r);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_go && !holdoff_taken) begin
        holdoff_taken = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    display_req_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        r.kind = sssd_req_t'(in_req_type);
        r.digit[0] = in_digit_value_0;
        r.digit[1] = in_digit_value_1;
        r.digit[2] = in_digit_value_2;
        r.digit[3] = in_digit_value_3;
        r.number = in_number_value;
        r.point = in_point_position;
        sb.note_request(r);
      end
      if (out_valid && out_ready) sb.check_result(out_segment_bits, out_select_code);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_seven_segment_scan_driver_unit: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int pick;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_WRITE_DIGITS;
    in_digit_value_0  <= '0;
    in_digit_value_1  <= '0;
    in_digit_value_2  <= '0;
    in_digit_value_3  <= '0;
    in_number_value   <= '0;
    in_point_position <= '0;
    out_ready         <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick();
    send_digits(31, -32, 16, 15);
    send_point(3);
    repeat (4) send_tick();
    send_digits(-1, 0, 9, 10);
    send_point(-8);
    send_tick();
    send_point(7);
    send_point(4);
    send_tick();
    send_point(0);
    send_tick();
    send_number(-16384);
    repeat (2) send_tick();
    send_number(16383);
    send_number(1234);
    send_point(-1);
    repeat (4) send_tick();
    wait_for_drain();

    for (int i = 0; i < ITEM_COUNT; i++) begin
      if (i == 150) steady = 1'b1;
      if (i == 250) steady = 1'b0;
      if (i == 300) holdoff_go = 1'b1;
      if (i == 400) wait_for_drain();
      if (i >= 300 && i < 340) begin
        send_tick();
      end else begin
        pick = $urandom_range(99);
        if (pick < 50) drive_request(rand_request(REQ_SCAN_TICK));
        else if (pick < 67) drive_request(rand_request(REQ_WRITE_DIGITS));
        else if (pick < 84) drive_request(rand_request(REQ_WRITE_NUMBER));
        else drive_request(rand_request(REQ_SET_POINT));
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_seven_segment_scan_driver_unit: clean");
    end else begin
      $display("tb_seven_segment_scan_driver_unit: errors");
    end
    $finish;
  end

endmodule
